// ===== design/kcl_pkg.sv =====
// Shared types and codes for the keypad code lock controller.
`timescale 1ns / 1ps
`default_nettype none

package kcl_pkg;

    // Fixed field widths
    localparam int CODE_W    = 24;
    localparam int LIMIT_W   = 4;
    localparam int SECONDS_W = 8;
    localparam int WRONG_W   = 4;
    localparam int LENGTH_W  = 5;
    localparam int CFG_IDX_W = 3;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 24;

    localparam logic [WRONG_W-1:0] WRONG_MAX = 4'd15;

    // Keypad codes
    localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [3:0] KEY_STAR      = 4'd10;
    localparam logic [3:0] KEY_HASH      = 4'd11;

    // Remote command bytes
    localparam logic [7:0] RB_UNLOCK = 8'h31;
    localparam logic [7:0] RB_WRONG  = 8'h30;

    // Reset values of the configuration registers
    localparam logic [CODE_W-1:0]    UNLOCK_CODE_RST     = 24'h000000;
    localparam logic [CODE_W-1:0]    TOGGLE_CODE_RST     = 24'h999999;
    localparam logic [LIMIT_W-1:0]   ATTEMPT_LIMIT_RST   = 4'd3;
    localparam logic [SECONDS_W-1:0] LOCKOUT_SECONDS_RST = 8'd30;
    localparam logic [SECONDS_W-1:0] OPEN_SECONDS_RST    = 8'd5;

    typedef enum logic [1:0] {
        KIND_KEY    = 2'd0,
        KIND_REMOTE = 2'd1,
        KIND_TICK   = 2'd2,
        KIND_UNUSED = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_OPEN    = 2'd1,
        MODE_LOCKOUT = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_UNLOCK = 2'd1,
        CMD_WRONG  = 2'd2,
        CMD_OTHER  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        EV_NONE          = 4'd0,
        EV_CODE_UNLOCK   = 4'd1,
        EV_REMOTE_UNLOCK = 4'd2,
        EV_OVERRIDE      = 4'd3,
        EV_PRIVACY_ON    = 4'd4,
        EV_PRIVACY_OFF   = 4'd5,
        EV_WRONG         = 4'd6,
        EV_LOCKOUT       = 4'd7,
        EV_LOCKOUT_END   = 4'd8,
        EV_RELOCK        = 4'd9
    } event_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UNLOCK_CODE     = 3'd0,
        CFG_TOGGLE_CODE     = 3'd1,
        CFG_ATTEMPT_LIMIT   = 3'd2,
        CFG_LOCKOUT_SECONDS = 3'd3,
        CFG_OPEN_SECONDS    = 3'd4
    } cfg_idx_t;

endpackage

`default_nettype wire

// ===== design/keypad_code_lock_controller.sv =====
// Keypad code lock with remote commands, privacy mode and attempt lockout.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Signals                                 Contents
// s_        in   s_tvalid s_tready s_tdata s_tuser       key press / remote byte / tick
// m_        out  m_tvalid m_tready m_tdata               status and event, one per input
// cfg_      in   cfg_valid cfg_ready cfg_index cfg_data  register writes, always ready
//
// One transaction per clock is sustained while m_tready stays high; each one passes
// the input register, then the full state update in one pass into the result register.
// aresetn is synchronous and active low; it clears mode, counters, flags and the
// held remote command and restores the register defaults.
// A stalled m_ side holds the result; the input register still takes one more
// transaction, then s_tready drops until the result moves.
module keypad_code_lock_controller
    import kcl_pkg::*;
#(
    parameter int ENTRY_DEPTH = 16,
    parameter int CODE_DIGITS = 6
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,   // [3:0] key_code, [11:4] remote_byte, rest 0
    input  wire logic [1:0]            s_tuser,   // [1:0] kind
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_DATA_W-1:0]        m_tdata,   // [0] door_open, [1] privacy_on,
                                                  // [2] locked_out, [7:3] entry_length,
                                                  // [15:8] seconds_left, [19:16] wrong_total,
                                                  // [23:20] event_res
    // configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CODE_W-1:0]     cfg_data
);

    localparam int CNT_W = $clog2(ENTRY_DEPTH + 1);
    localparam int IDX_W = $clog2(ENTRY_DEPTH);

    // ------------------------------------------------------------------
    // Configuration registers: written any time, the port never stalls.
    // ------------------------------------------------------------------
    logic [CODE_W-1:0]    unlock_code_reg;
    logic [CODE_W-1:0]    toggle_code_reg;
    logic [LIMIT_W-1:0]   attempt_limit_reg;
    logic [SECONDS_W-1:0] lockout_seconds_reg;
    logic [SECONDS_W-1:0] open_seconds_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unlock_code_reg     <= UNLOCK_CODE_RST;
            toggle_code_reg     <= TOGGLE_CODE_RST;
            attempt_limit_reg   <= ATTEMPT_LIMIT_RST;
            lockout_seconds_reg <= LOCKOUT_SECONDS_RST;
            open_seconds_reg    <= OPEN_SECONDS_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_UNLOCK_CODE:     unlock_code_reg     <= cfg_data;
                CFG_TOGGLE_CODE:     toggle_code_reg     <= cfg_data;
                CFG_ATTEMPT_LIMIT:   attempt_limit_reg   <= cfg_data[LIMIT_W-1:0];
                CFG_LOCKOUT_SECONDS: lockout_seconds_reg <= cfg_data[SECONDS_W-1:0];
                CFG_OPEN_SECONDS:    open_seconds_reg    <= cfg_data[SECONDS_W-1:0];
                default: ;  // indexes beyond the list are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register and handshake. The item in the input register is
    // processed when the result register is empty or being drained.
    // ------------------------------------------------------------------
    logic       in_valid_reg;
    kind_t      in_kind_reg;
    logic [3:0] in_key_reg;
    logic [7:0] in_byte_reg;
    logic       advance;
    logic       m_tvalid_reg;

    assign advance  = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_kind_reg <= kind_t'(s_tuser);
            in_key_reg  <= s_tdata[3:0];
            in_byte_reg <= s_tdata[11:4];
        end
    end

    // ------------------------------------------------------------------
    // Lock state
    // ------------------------------------------------------------------
    mode_t                mode_reg,       mode_next;
    cmd_t                 pending_reg,    pending_next;
    logic [CNT_W-1:0]     entry_count_reg, entry_count_next;
    logic [WRONG_W-1:0]   wrong_count_reg, wrong_count_next;
    logic                 privacy_reg,    privacy_next;
    logic [SECONDS_W-1:0] timer_reg,      timer_next;
    event_t               ev_next;

    // Entered digits; only positions below the count are ever compared.
    logic [3:0]           digit_store_reg [ENTRY_DEPTH];
    logic                 digit_we;

    // Compare the leading digits with both codes, first digit in the top nibble.
    logic [CODE_DIGITS-1:0] unlock_nib_eq;
    logic [CODE_DIGITS-1:0] toggle_nib_eq;
    logic                   long_enough;
    logic                   unlock_hit;
    logic                   toggle_hit;

    for (genvar i = 0; i < CODE_DIGITS; i++) begin : g_cmp
        localparam int SH = 4 * (CODE_DIGITS - 1 - i);
        if (i < ENTRY_DEPTH && SH < CODE_W) begin : g_live
            assign unlock_nib_eq[i] = (unlock_code_reg[SH +: 4] == digit_store_reg[i]);
            assign toggle_nib_eq[i] = (toggle_code_reg[SH +: 4] == digit_store_reg[i]);
        end else if (i < ENTRY_DEPTH) begin : g_zero
            // code nibbles beyond the register read as zero
            assign unlock_nib_eq[i] = (digit_store_reg[i] == 4'd0);
            assign toggle_nib_eq[i] = (digit_store_reg[i] == 4'd0);
        end else begin : g_none
            assign unlock_nib_eq[i] = 1'b0;
            assign toggle_nib_eq[i] = 1'b0;
        end
    end

    assign long_enough = (32'(entry_count_reg) >= CODE_DIGITS);
    assign unlock_hit  = long_enough && (&unlock_nib_eq);
    assign toggle_hit  = long_enough && (&toggle_nib_eq);

    // Wrong-attempt arithmetic: saturating count, then compare to the limit.
    logic [WRONG_W-1:0] wrong_inc;
    assign wrong_inc = (wrong_count_reg < WRONG_MAX) ? wrong_count_reg + WRONG_W'(1)
                                                      : wrong_count_reg;

    always_comb begin
        logic   do_open;
        logic   do_wrong;
        event_t open_ev;
        cmd_t   cmd;
        cmd_t   run_cmd;
        logic   run;

        mode_next        = mode_reg;
        pending_next     = pending_reg;
        entry_count_next = entry_count_reg;
        wrong_count_next = wrong_count_reg;
        privacy_next     = privacy_reg;
        timer_next       = timer_reg;
        ev_next          = EV_NONE;
        digit_we         = 1'b0;
        do_open          = 1'b0;
        do_wrong         = 1'b0;
        open_ev          = EV_NONE;
        cmd              = CMD_OTHER;
        run_cmd          = CMD_NONE;
        run              = 1'b0;

        unique case (in_kind_reg)
            KIND_KEY: begin
                if (mode_reg == MODE_IDLE) begin
                    if (in_key_reg <= KEY_DIGIT_MAX) begin
                        if (entry_count_reg < CNT_W'(ENTRY_DEPTH)) begin
                            digit_we         = 1'b1;
                            entry_count_next = entry_count_reg + CNT_W'(1);
                        end
                    end else if (in_key_reg == KEY_STAR) begin
                        if (entry_count_reg != '0) begin
                            entry_count_next = entry_count_reg - CNT_W'(1);
                        end
                    end else if (in_key_reg == KEY_HASH) begin
                        if (unlock_hit) begin
                            do_open = 1'b1;
                            open_ev = EV_CODE_UNLOCK;
                        end else if (toggle_hit) begin
                            entry_count_next = '0;
                            privacy_next     = !privacy_reg;
                            ev_next          = privacy_reg ? EV_PRIVACY_OFF : EV_PRIVACY_ON;
                        end else begin
                            do_wrong = 1'b1;
                        end
                    end
                end
            end
            KIND_REMOTE: begin
                if (in_byte_reg == RB_UNLOCK) begin
                    cmd = CMD_UNLOCK;
                end else if (in_byte_reg == RB_WRONG) begin
                    cmd = CMD_WRONG;
                end
                if (cmd == CMD_UNLOCK && privacy_reg) begin
                    // privacy drops a remote unlock without touching the held command
                end else if (mode_reg == MODE_LOCKOUT && cmd == CMD_UNLOCK) begin
                    pending_next = CMD_NONE;
                    do_open      = 1'b1;
                    open_ev      = EV_OVERRIDE;
                end else if (mode_reg != MODE_IDLE) begin
                    pending_next = cmd;  // last byte wins
                end else begin
                    pending_next = CMD_NONE;
                    run          = 1'b1;
                    run_cmd      = cmd;
                end
            end
            KIND_TICK: begin
                if (mode_reg == MODE_IDLE) begin
                    pending_next = CMD_NONE;
                    run          = 1'b1;
                    run_cmd      = pending_reg;
                end else if (timer_reg > SECONDS_W'(1)) begin
                    timer_next = timer_reg - SECONDS_W'(1);
                end else begin
                    timer_next       = '0;
                    entry_count_next = '0;
                    mode_next        = MODE_IDLE;
                    if (mode_reg == MODE_LOCKOUT) begin
                        wrong_count_next = '0;
                        ev_next          = EV_LOCKOUT_END;
                    end else begin
                        ev_next = EV_RELOCK;
                    end
                end
            end
            default: ;  // unused kind: no change
        endcase

        if (run) begin
            if (run_cmd == CMD_UNLOCK) begin
                do_open = 1'b1;
                open_ev = EV_REMOTE_UNLOCK;
            end else if (run_cmd == CMD_WRONG) begin
                do_wrong = 1'b1;
            end
        end

        if (do_open) begin
            wrong_count_next = '0;
            mode_next        = MODE_OPEN;
            timer_next       = open_seconds_reg;
            entry_count_next = '0;
            ev_next          = open_ev;
        end

        if (do_wrong) begin
            entry_count_next = '0;
            wrong_count_next = wrong_inc;
            if (wrong_inc >= attempt_limit_reg) begin
                mode_next  = MODE_LOCKOUT;
                timer_next = lockout_seconds_reg;
                ev_next    = EV_LOCKOUT;
            end else begin
                ev_next = EV_WRONG;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_IDLE;
            pending_reg     <= CMD_NONE;
            entry_count_reg <= '0;
            wrong_count_reg <= '0;
            privacy_reg     <= 1'b0;
            timer_reg       <= '0;
        end else if (advance) begin
            mode_reg        <= mode_next;
            pending_reg     <= pending_next;
            entry_count_reg <= entry_count_next;
            wrong_count_reg <= wrong_count_next;
            privacy_reg     <= privacy_next;
            timer_reg       <= timer_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && digit_we) begin
            digit_store_reg[entry_count_reg[IDX_W-1:0]] <= in_key_reg;
        end
    end

    // ------------------------------------------------------------------
    // Result register: load on advance, drop valid once taken.
    // ------------------------------------------------------------------
    logic [M_DATA_W-1:0]  m_tdata_reg;
    logic [SECONDS_W-1:0] seconds_left;

    assign seconds_left = (mode_next == MODE_IDLE) ? '0 : timer_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tdata_reg <= {ev_next,
                            wrong_count_next,
                            seconds_left,
                            LENGTH_W'(entry_count_next),
                            (mode_next == MODE_LOCKOUT),
                            privacy_next,
                            (mode_next == MODE_OPEN)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    // The entry count never runs past the digit store.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(entry_count_reg) <= ENTRY_DEPTH)
        else $error("entry count beyond digit store");

    // Every busy period starts from a cleared entry and keys are ignored while busy.
    a_busy_no_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg != MODE_IDLE |-> entry_count_reg == '0)
        else $error("digits held while busy");

    // Idle is only reached with the period timer run down.
    a_idle_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_IDLE |-> timer_reg == '0)
        else $error("period timer left running in idle");

    // Entering lockout from idle always reports the lockout event.
    a_lockout_event: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && mode_reg == MODE_IDLE && mode_next == MODE_LOCKOUT
            |=> m_tdata_reg[23:20] == EV_LOCKOUT)
        else $error("lockout entered without lockout event");
`endif

endmodule

`default_nettype wire

// ===== bench/keypad_code_lock_controller_tb.sv =====
// Self-checking testbench for the keypad code lock controller: lock model and stimulus.
`timescale 1ns / 1ps

import kcl_pkg::*;

// Lock model and result checker. The model tracks the same state as the block
// and queues one expected status word for every input transaction.
class lock_scoreboard;
    localparam int ENTRY_DEPTH = 16;
    localparam int CODE_DIGITS = 6;

    // Same bit layout as m_tdata, event in the top nibble
    typedef struct packed {
        event_t               ev;
        logic [WRONG_W-1:0]   wrong;
        logic [SECONDS_W-1:0] secs;
        logic [LENGTH_W-1:0]  len;
        logic                 lockout;
        logic                 privacy;
        logic                 door;
    } status_t;

    logic [CODE_W-1:0]    unlock_code;
    logic [CODE_W-1:0]    toggle_code;
    logic [LIMIT_W-1:0]   attempt_limit;
    logic [SECONDS_W-1:0] lockout_secs;
    logic [SECONDS_W-1:0] open_secs;

    logic [3:0]           digits [ENTRY_DEPTH];
    int unsigned          entered;
    logic [WRONG_W-1:0]   wrong_cnt;
    bit                   privacy;
    mode_t                mode;
    logic [SECONDS_W-1:0] timer;
    cmd_t                 held;

    status_t              status_q[$];
    int                   errors;
    int                   results_seen;

    function new();
        unlock_code   = UNLOCK_CODE_RST;
        toggle_code   = TOGGLE_CODE_RST;
        attempt_limit = ATTEMPT_LIMIT_RST;
        lockout_secs  = LOCKOUT_SECONDS_RST;
        open_secs     = OPEN_SECONDS_RST;
        foreach (digits[i]) digits[i] = 4'd0;
        entered      = 0;
        wrong_cnt    = '0;
        privacy      = 1'b0;
        mode         = MODE_IDLE;
        timer        = '0;
        held         = CMD_NONE;
        errors       = 0;
        results_seen = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CODE_W-1:0] value);
        case (idx)
            CFG_UNLOCK_CODE:     unlock_code   = value;
            CFG_TOGGLE_CODE:     toggle_code   = value;
            CFG_ATTEMPT_LIMIT:   attempt_limit = value[LIMIT_W-1:0];
            CFG_LOCKOUT_SECONDS: lockout_secs  = value[SECONDS_W-1:0];
            CFG_OPEN_SECONDS:    open_secs     = value[SECONDS_W-1:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return status_q.size();
    endfunction

    // First digit entered sits in the top nibble of the code
    function bit code_match(logic [CODE_W-1:0] code);
        if (entered < CODE_DIGITS)
            return 1'b0;
        for (int i = 0; i < CODE_DIGITS; i++)
            if (code[(CODE_DIGITS - 1 - i) * 4 +: 4] != digits[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function event_t open_door(event_t ev);
        wrong_cnt = '0;
        mode      = MODE_OPEN;
        timer     = open_secs;
        entered   = 0;
        return ev;
    endfunction

    function event_t wrong_try();
        entered = 0;
        if (wrong_cnt != WRONG_MAX)
            wrong_cnt++;
        if (wrong_cnt >= attempt_limit) begin
            mode  = MODE_LOCKOUT;
            timer = lockout_secs;
            return EV_LOCKOUT;
        end
        return EV_WRONG;
    endfunction

    function event_t run_cmd(cmd_t cmd);
        if (cmd == CMD_UNLOCK)
            return open_door(EV_REMOTE_UNLOCK);
        if (cmd == CMD_WRONG)
            return wrong_try();
        return EV_NONE;
    endfunction

    function void note_input(kind_t kind, logic [3:0] key, logic [7:0] rbyte);
        event_t  ev;
        cmd_t    cmd;
        status_t want;
        ev = EV_NONE;
        case (kind)
            KIND_KEY: begin
                if (mode == MODE_IDLE) begin
                    if (key <= KEY_DIGIT_MAX) begin
                        if (entered < ENTRY_DEPTH) begin
                            digits[entered] = key;
                            entered++;
                        end
                    end else if (key == KEY_STAR) begin
                        if (entered > 0)
                            entered--;
                    end else if (key == KEY_HASH) begin
                        if (code_match(unlock_code)) begin
                            ev = open_door(EV_CODE_UNLOCK);
                        end else if (code_match(toggle_code)) begin
                            entered = 0;
                            privacy = !privacy;
                            ev = privacy ? EV_PRIVACY_ON : EV_PRIVACY_OFF;
                        end else begin
                            ev = wrong_try();
                        end
                    end
                end
            end
            KIND_REMOTE: begin
                if (rbyte == RB_UNLOCK)
                    cmd = CMD_UNLOCK;
                else if (rbyte == RB_WRONG)
                    cmd = CMD_WRONG;
                else
                    cmd = CMD_OTHER;
                // an unlock under privacy vanishes without touching the held command
                if (!(cmd == CMD_UNLOCK && privacy)) begin
                    if (mode == MODE_LOCKOUT && cmd == CMD_UNLOCK) begin
                        held = CMD_NONE;
                        ev = open_door(EV_OVERRIDE);
                    end else if (mode != MODE_IDLE) begin
                        held = cmd;
                    end else begin
                        held = CMD_NONE;
                        ev = run_cmd(cmd);
                    end
                end
            end
            KIND_TICK: begin
                if (mode == MODE_IDLE) begin
                    cmd  = held;
                    held = CMD_NONE;
                    ev   = run_cmd(cmd);
                end else if (timer > 8'd1) begin
                    timer--;
                end else begin
                    timer   = '0;
                    entered = 0;
                    ev = (mode == MODE_LOCKOUT) ? EV_LOCKOUT_END : EV_RELOCK;
                    if (mode == MODE_LOCKOUT)
                        wrong_cnt = '0;
                    mode = MODE_IDLE;
                end
            end
            default: ;
        endcase

        want.ev      = ev;
        want.wrong   = wrong_cnt;
        want.secs    = (mode == MODE_IDLE) ? 8'd0 : timer;
        want.len     = 5'(entered);
        want.lockout = (mode == MODE_LOCKOUT);
        want.privacy = privacy;
        want.door    = (mode == MODE_OPEN);
        status_q.push_back(want);
    endfunction

    task report(string what, logic [23:0] got, logic [23:0] want);
        errors++;
        $display("MISMATCH result %0d %s: got %0h, expected %0h",
                 results_seen, what, got, want);
    endtask

    task check_result(logic [23:0] data);
        status_t got;
        status_t want;
        got = data;
        results_seen++;
        if (status_q.size() == 0) begin
            report("unexpected result", data, 24'd0);
            return;
        end
        want = status_q.pop_front();
        if (got.door !== want.door)
            report("door_open", 24'(got.door), 24'(want.door));
        if (got.privacy !== want.privacy)
            report("privacy_on", 24'(got.privacy), 24'(want.privacy));
        if (got.lockout !== want.lockout)
            report("locked_out", 24'(got.lockout), 24'(want.lockout));
        if (got.len !== want.len)
            report("entry_length", 24'(got.len), 24'(want.len));
        if (got.secs !== want.secs)
            report("seconds_left", 24'(got.secs), 24'(want.secs));
        if (got.wrong !== want.wrong)
            report("wrong_total", 24'(got.wrong), 24'(want.wrong));
        if (got.ev !== want.ev)
            report("event_res", 24'(got.ev), 24'(want.ev));
    endtask
endclass

module keypad_code_lock_controller_tb;
    import kcl_pkg::*;

    localparam int HALF_PERIOD     = 2;
    localparam int CODE_DIGITS     = 6;
    localparam int LIMIT_CYCLES    = 400000;
    localparam int PRESSURE_CYCLES = 300;
    localparam int TAIL_CYCLES     = 8;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata   = '0;    // [3:0] key_code, [11:4] remote_byte, rest 0
    logic [1:0]           s_tuser   = '0;    // [1:0] kind
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;           // [0] door, [1] privacy, [2] lockout,
                                             // [7:3] length, [15:8] seconds,
                                             // [19:16] wrong, [23:20] event
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CODE_W-1:0]    cfg_data  = '0;

    // Idle rates in percent of cycles, changed per phase
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent    = 0;
    bit pressure_go   = 1'b0;
    bit rx_hold       = 1'b0;

    lock_scoreboard sb;

    keypad_code_lock_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // Receiver: drop ready at random, and hold it low for the whole
    // pressure window so the block backs up into its input.
    always @(posedge aclk) begin
        m_tready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Long receiver hold-off, counted here while the sender keeps offering.
    initial begin : rx_pressure
        int held;
        wait (pressure_go);
        @(posedge aclk);
        rx_hold <= 1'b1;
        for (held = 0; held < PRESSURE_CYCLES; held++)
            @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // Monitor: note each accepted input transaction before checking the result
    // of the same edge, so the expectation is always queued first.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_input(kind_t'(s_tuser), s_tdata[3:0], s_tdata[11:4]);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Watchdog: end the run if it hangs.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // Offer one input transaction and hold it until the block takes it.
    // Idle cycles go in front, so valid is never lowered and raised in one step.
    task automatic send(kind_t kind, logic [3:0] key, logic [7:0] rbyte);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0000, rbyte, key};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // The unused field carries random bits as noise
    task automatic send_key(logic [3:0] key);
        send(KIND_KEY, key, 8'($urandom));
    endtask

    task automatic send_remote(logic [7:0] rbyte);
        send(KIND_REMOTE, 4'($urandom), rbyte);
    endtask

    task automatic send_ticks(int count);
        for (int i = 0; i < count; i++)
            send(KIND_TICK, 4'($urandom), 8'($urandom));
    endtask

    // Key in a six-digit code, first digit from the top nibble
    task automatic enter_code(logic [CODE_W-1:0] code);
        for (int i = CODE_DIGITS - 1; i >= 0; i--)
            send_key(code[i * 4 +: 4]);
    endtask

    // Unused kind, unused key codes, stray deletes, or anything at all
    task automatic send_noise();
        case ($urandom_range(3))
            0: send(KIND_UNUSED, 4'($urandom), 8'($urandom));
            1: send_key(4'($urandom_range(12, 15)));
            2: send_key(KEY_STAR);
            default: send(kind_t'($urandom_range(3)), 4'($urandom), 8'($urandom));
        endcase
    endtask

    function automatic logic [7:0] pick_remote();
        int r;
        r = $urandom_range(9);
        if (r < 4)
            return RB_UNLOCK;
        if (r < 8)
            return RB_WRONG;
        return 8'($urandom);
    endfunction

    function automatic logic [CODE_W-1:0] rand_bcd();
        logic [CODE_W-1:0] code;
        for (int i = 0; i < CODE_DIGITS; i++)
            code[i * 4 +: 4] = 4'($urandom_range(0, 9));
        return code;
    endfunction

    // One register write transaction; the model follows at the same edge
    task automatic write_reg(cfg_idx_t idx, logic [CODE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, value);
    endtask

    task automatic write_setting(logic [CODE_W-1:0] unlock, logic [CODE_W-1:0] toggle,
                                 logic [LIMIT_W-1:0] limit, logic [SECONDS_W-1:0] lock_s,
                                 logic [SECONDS_W-1:0] open_s);
        write_reg(CFG_UNLOCK_CODE, unlock);
        write_reg(CFG_TOGGLE_CODE, toggle);
        write_reg(CFG_ATTEMPT_LIMIT, CODE_W'(limit));
        write_reg(CFG_LOCKOUT_SECONDS, CODE_W'(lock_s));
        write_reg(CFG_OPEN_SECONDS, CODE_W'(open_s));
        cfg_valid <= 1'b0;
    endtask

    // Drop valid and hold until every expected result has come back
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // Mostly well-formed entries with random content; shaped by the model's mode
    // so open and lockout periods get ticked out, overridden or fed commands.
    task automatic random_phase(int count);
        int stop;
        int n;
        int r;
        stop = items_sent + count;
        while (items_sent < stop) begin
            if (sb.mode != MODE_IDLE) begin
                r = $urandom_range(99);
                if (r < 10)
                    send_ticks(int'(sb.timer) + 2);    // run out, then act on a held command
                else if (r < 55)
                    send_ticks($urandom_range(1, 3));
                else if (r < 80)
                    send_remote(pick_remote());
                else
                    send_noise();
            end else begin
                case ($urandom_range(9))
                    0, 1, 2: begin
                        // correct code, sometimes after a fixed typo or with trailing digits
                        if ($urandom_range(2) == 0) begin
                            send_key(4'($urandom_range(0, 9)));
                            send_key(KEY_STAR);
                        end
                        enter_code(sb.unlock_code);
                        n = ($urandom_range(3) == 0) ? $urandom_range(1, 12) : 0;
                        for (int i = 0; i < n; i++)
                            send_key(4'($urandom_range(0, 9)));
                        send_key(KEY_HASH);
                    end
                    3: begin
                        enter_code(sb.toggle_code);
                        send_key(KEY_HASH);
                    end
                    4, 5: begin
                        // short, wrong or overlong entries with stray deletes
                        n = $urandom_range(0, 20);
                        for (int i = 0; i < n; i++)
                            send_key(($urandom_range(7) == 0) ? KEY_STAR
                                                              : 4'($urandom_range(0, 9)));
                        send_key(KEY_HASH);
                    end
                    6: send_remote(pick_remote());
                    7: send_ticks($urandom_range(1, 3));
                    default: send_noise();
                endcase
            end
        end
    endtask

    initial begin : main
        logic [CODE_W-1:0] shared_code;
        sb = new();

        // Hold reset low at the start, then release it for good
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: short deadlines so every path shows up quickly
        send_idle_pct = 30;
        recv_idle_pct = 84;
        write_setting(24'h123456, 24'h654321, 4'd2, 8'd3, 8'd2);
        send(KIND_UNUSED, 4'hF, 8'hFF);       // unused kind
        send_key(4'd15);                      // unused key codes
        send_key(4'd12);
        send_key(KEY_STAR);                   // delete with nothing entered
        send_ticks(1);                        // idle tick, nothing held
        send_key(4'd0);
        send_key(KEY_DIGIT_MAX);
        send_key(KEY_HASH);                   // short entry counts as wrong
        send_remote(RB_WRONG);                // second wrong starts lockout
        send_key(4'd5);                       // keys ignored while busy
        send_remote(RB_WRONG);                // held ...
        send_remote(8'h00);                   // ... and replaced, last one wins
        send_remote(RB_UNLOCK);               // override ends lockout, door opens
        send_remote(RB_WRONG);                // held while open
        send_ticks(3);                        // count down, relock, run held wrong
        enter_code(24'h654321);
        send_key(KEY_HASH);                   // privacy on
        send_remote(RB_UNLOCK);               // dropped under privacy
        wait_drain();

        // Phase 1: range extremes, one-tick periods, lockout on first wrong;
        // the receiver also backs off for a long stretch here.
        write_setting(24'h000000, 24'h999999, 4'd1, 8'd1, 8'd1);
        pressure_go = 1'b1;
        random_phase(380);
        wait_drain();

        // Phase 2: both codes equal so unlock must win, zero lockout period
        send_idle_pct = 84;
        recv_idle_pct = 30;
        shared_code = rand_bcd();
        write_setting(shared_code, shared_code, 4'd15, 8'd0, 8'd255);
        random_phase(380);
        wait_drain();

        // Phase 3: unlock code with a non-decimal nibble never matches,
        // attempt limit zero, zero open period, longest lockout; no idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_setting(24'h12A456, rand_bcd(), 4'd0, 8'd255, 8'd0);
        random_phase(390);
        wait_drain();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== keypad_code_lock_controller.f =====
design/kcl_pkg.sv
design/keypad_code_lock_controller.sv
bench/keypad_code_lock_controller_tb.sv
